/* rtl/scr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spherical rotation package
// Shared fixed point types, register indexes and CORDIC constants.
// ----------------------------------------------------------------------------
package scr_pkg;

  // Trig values are signed with QF fraction bits.
  localparam int QF = 60;
  typedef logic signed [63:0] q_t;

  localparam q_t Q_ONE = q_t'(64'd1 << QF);

  // Pipeline depths of the fixed units.
  localparam int MUL_LAT  = 4;
  localparam int SQRT_LAT = QF + 1;
  localparam int SQRT_IN_W = 2 * QF + 1;

  // Configuration port.
  localparam int CFG_INDEX_W = 4;
  localparam logic [CFG_INDEX_W-1:0] REG_TILT     = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_NODE     = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET   = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_IDENTITY = 4'd3;

  // Quadrant of a phase, taken from its two top bits.
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  // Latitude limit of a quarter turn in 32-bit turn units.
  localparam logic signed [31:0] LAT_LIMIT = 32'sh4000_0000;

  localparam logic [63:0] INV_TWO_PI_Q64 = 64'h28BE_60DB_9391_054A;

  // CORDIC start value: the gain of an unbounded number of stages.
  localparam logic [127:0] GAIN_SCALED =
    (128'd607252935008881256 << QF) / 128'd1000000000000000000;
  localparam q_t GAIN_K = q_t'(GAIN_SCALED[63:0]);

  // Shift and subtract quotient, used only while the tables elaborate.
  function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Arctangent of 2^-idx as a fraction of a turn with ab bits, rounded.
  // The radian value comes from the alternating arctangent series.
  function automatic logic [63:0] atan_entry(input int idx, input int ab);
    logic [63:0]  rad;
    logic [63:0]  term;
    logic [127:0] prod;
    int           e;
    rad = '0;
    if (idx == 0) begin
      return 64'd1 << (ab - 3);
    end
    for (int k = 0; k < 32; k++) begin
      e = idx * (2 * k + 1);
      if (e <= 62) begin
        term = udiv(64'd1 << (62 - e), 64'(2 * k + 1));
        if ((k & 1) != 0) begin
          rad = rad - term;
        end else begin
          rad = rad + term;
        end
      end
    end
    prod = {64'd0, rad} * {64'd0, INV_TWO_PI_Q64};
    return (prod[127:64] + (64'd1 << (61 - ab))) >> (62 - ab);
  endfunction

endpackage

/* rtl/scr_delay.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delay line
// Holds a payload for a fixed number of pipeline steps, advancing on enable.
// ----------------------------------------------------------------------------
module scr_delay #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] tap_r [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        tap_r[i] <= tap_r[i-1];
      end
    end
  end

  assign q = tap_r[DEPTH-1];

endmodule

/* rtl/scr_qmul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed point multiplier
// Signed Q60 product truncated toward zero, built from four 32x32 partials.
// ----------------------------------------------------------------------------
module scr_qmul (
  input  logic        clk,
  input  logic        en,
  input  scr_pkg::q_t a,
  input  scr_pkg::q_t b,
  output scr_pkg::q_t p
);

  logic        neg1_r, neg2_r, neg3_r;
  logic [63:0] ua_r, ub_r, ua_nxt, ub_nxt;
  logic [63:0] p00_r, p01_r, p10_r, p11_r;
  logic [62:0] mag_r, mag_nxt;
  logic [127:0] prod;
  scr_pkg::q_t p_r, p_nxt;

  always_comb begin
    ua_nxt = a[63] ? 64'(-a) : 64'(a);
    ub_nxt = b[63] ? 64'(-b) : 64'(b);
    prod = {64'd0, p00_r} + {32'd0, p01_r, 32'd0} + {32'd0, p10_r, 32'd0}
         + {p11_r, 64'd0};
    mag_nxt = prod[122:scr_pkg::QF];
    p_nxt = neg3_r ? -scr_pkg::q_t'({1'b0, mag_r}) : scr_pkg::q_t'({1'b0, mag_r});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg1_r <= a[63] ^ b[63];
      ua_r   <= ua_nxt;
      ub_r   <= ub_nxt;
      neg2_r <= neg1_r;
      p00_r  <= ua_r[31:0]  * ub_r[31:0];
      p01_r  <= ua_r[31:0]  * ub_r[63:32];
      p10_r  <= ua_r[63:32] * ub_r[31:0];
      p11_r  <= ua_r[63:32] * ub_r[63:32];
      neg3_r <= neg2_r;
      mag_r  <= mag_nxt;
      p_r    <= p_nxt;
    end
  end

  assign p = p_r;

endmodule

/* rtl/scr_sincos.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sine and cosine unit
// Rotation CORDIC on the residue within a quarter turn, one stage per
// iteration, followed by a quadrant swap.
// ----------------------------------------------------------------------------
module scr_sincos #(
  parameter int ANGLE_BITS    = 32,
  parameter int CORDIC_STAGES = 32
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [ANGLE_BITS-1:0] ang,
  output scr_pkg::q_t           cos_o,
  output scr_pkg::q_t           sin_o
);

  typedef logic signed [ANGLE_BITS:0] res_t;

  scr_pkg::q_t x_r [CORDIC_STAGES+1];
  scr_pkg::q_t y_r [CORDIC_STAGES+1];
  res_t        z_r [CORDIC_STAGES+1];
  logic [1:0]  quad_r [CORDIC_STAGES+1];
  scr_pkg::q_t cos_r, sin_r, cos_nxt, sin_nxt;

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= scr_pkg::GAIN_K;
      y_r[0]    <= '0;
      z_r[0]    <= res_t'({3'b000, ang[ANGLE_BITS-3:0]});
      quad_r[0] <= ang[ANGLE_BITS-1 -: 2];
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    localparam logic [63:0] ATAN_FULL = scr_pkg::atan_entry(i, ANGLE_BITS);
    localparam res_t ATAN = res_t'(ATAN_FULL[ANGLE_BITS:0]);
    scr_pkg::q_t x_nxt, y_nxt;
    res_t        z_nxt;

    always_comb begin
      if (!z_r[i][ANGLE_BITS]) begin
        x_nxt = x_r[i] - (y_r[i] >>> i);
        y_nxt = y_r[i] + (x_r[i] >>> i);
        z_nxt = z_r[i] - ATAN;
      end else begin
        x_nxt = x_r[i] + (y_r[i] >>> i);
        y_nxt = y_r[i] - (x_r[i] >>> i);
        z_nxt = z_r[i] + ATAN;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i+1]    <= x_nxt;
        y_r[i+1]    <= y_nxt;
        z_r[i+1]    <= z_nxt;
        quad_r[i+1] <= quad_r[i];
      end
    end
  end

  always_comb begin
    unique case (quad_r[CORDIC_STAGES])
      scr_pkg::QUAD_0: begin
        cos_nxt = x_r[CORDIC_STAGES];
        sin_nxt = y_r[CORDIC_STAGES];
      end
      scr_pkg::QUAD_1: begin
        cos_nxt = -y_r[CORDIC_STAGES];
        sin_nxt = x_r[CORDIC_STAGES];
      end
      scr_pkg::QUAD_2: begin
        cos_nxt = -x_r[CORDIC_STAGES];
        sin_nxt = -y_r[CORDIC_STAGES];
      end
      scr_pkg::QUAD_3: begin
        cos_nxt = y_r[CORDIC_STAGES];
        sin_nxt = -x_r[CORDIC_STAGES];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= cos_nxt;
      sin_r <= sin_nxt;
    end
  end

  assign cos_o = cos_r;
  assign sin_o = sin_r;

endmodule

/* rtl/scr_isqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer square root
// Floor square root of a 121-bit value, one root bit per stage, using the
// running remainder so that each stage is a single compare and subtract.
// ----------------------------------------------------------------------------
module scr_isqrt (
  input  logic                            clk,
  input  logic                            en,
  input  logic [scr_pkg::SQRT_IN_W-1:0]   n,
  output logic [scr_pkg::QF:0]            root
);

  localparam int NW = scr_pkg::SQRT_IN_W;
  localparam int RW = NW + 2;

  logic [NW-1:0]         rem_r  [scr_pkg::SQRT_LAT];
  logic [scr_pkg::QF:0]  root_r [scr_pkg::SQRT_LAT];

  for (genvar j = 0; j < scr_pkg::SQRT_LAT; j++) begin : g_bit
    localparam int B = scr_pkg::QF - j;
    logic [NW-1:0]        rem_in, rem_nxt;
    logic [scr_pkg::QF:0] root_in, root_nxt;
    logic [RW-1:0]        trial;

    if (j == 0) begin : g_first
      assign rem_in  = n;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_r[j-1];
      assign root_in = root_r[j-1];
    end

    // (root + 2^B)^2 - root^2 = root * 2^(B+1) + 2^(2B)
    always_comb begin
      trial = (RW'(root_in) << (B + 1)) + (RW'(1) << (2 * B));
      if ({2'b00, rem_in} >= trial) begin
        rem_nxt  = rem_in - trial[NW-1:0];
        root_nxt = root_in | ((scr_pkg::QF+1)'(1) << B);
      end else begin
        rem_nxt  = rem_in;
        root_nxt = root_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]  <= rem_nxt;
        root_r[j] <= root_nxt;
      end
    end
  end

  assign root = root_r[scr_pkg::SQRT_LAT-1];

endmodule

/* rtl/scr_atan2.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Arctangent unit
// Vectoring CORDIC with a half-turn pre-rotation for a negative x, one
// stage per iteration; the angle wraps modulo one turn.
// ----------------------------------------------------------------------------
module scr_atan2 #(
  parameter int ANGLE_BITS    = 32,
  parameter int CORDIC_STAGES = 32
) (
  input  logic                  clk,
  input  logic                  en,
  input  scr_pkg::q_t           y,
  input  scr_pkg::q_t           x,
  output logic [ANGLE_BITS-1:0] ang
);

  localparam logic [ANGLE_BITS-1:0] HALF_TURN = {1'b1, {(ANGLE_BITS-1){1'b0}}};

  scr_pkg::q_t           x_r [CORDIC_STAGES+1];
  scr_pkg::q_t           y_r [CORDIC_STAGES+1];
  logic [ANGLE_BITS-1:0] z_r [CORDIC_STAGES+1];

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= x[63] ? -x : x;
      y_r[0] <= x[63] ? -y : y;
      z_r[0] <= x[63] ? HALF_TURN : '0;
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    localparam logic [63:0] ATAN_FULL = scr_pkg::atan_entry(i, ANGLE_BITS);
    localparam logic [ANGLE_BITS-1:0] ATAN = ATAN_FULL[ANGLE_BITS-1:0];
    scr_pkg::q_t           x_nxt, y_nxt;
    logic [ANGLE_BITS-1:0] z_nxt;

    always_comb begin
      if (y_r[i][63]) begin
        x_nxt = x_r[i] - (y_r[i] >>> i);
        y_nxt = y_r[i] + (x_r[i] >>> i);
        z_nxt = z_r[i] - ATAN;
      end else begin
        x_nxt = x_r[i] + (y_r[i] >>> i);
        y_nxt = y_r[i] - (x_r[i] >>> i);
        z_nxt = z_r[i] + ATAN;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i+1] <= x_nxt;
        y_r[i+1] <= y_nxt;
        z_r[i+1] <= z_nxt;
      end
    end
  end

  assign ang = z_r[CORDIC_STAGES];

endmodule

/* rtl/spherical_coordinate_rotation.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spherical coordinate rotation
// Rotates a sky position into another spherical system set by three
// configured Euler angles, or passes it through in identity mode.
// ----------------------------------------------------------------------------
// Usage:
// An input beat on in_t* carries one position (longitude, latitude in turn
// units, 2^32 = one turn); out_t* returns exactly one rotated position per
// input beat, in order. The cfg_* channel writes tilt, node longitude,
// output offset and identity mode; it is always ready and should be used
// only while no position is in flight.
// The pipeline runs through two CORDIC chains, three rounds of multiplier
// stages and the 61-stage square root of the latitude path. A new beat is
// taken every cycle unless the output stalls.
// The whole pipeline advances as one; when out_tvalid is high and the
// receiver holds out_tready low, every stage freezes and in_tready drops
// until the waiting beat is taken. Bubbles move forward while the output
// register is empty.
// Reset empties the pipeline, clears the angles and the offset, and sets
// identity mode.
// ----------------------------------------------------------------------------
module spherical_coordinate_rotation #(
  parameter int ANGLE_BITS    = 32,
  parameter int CORDIC_STAGES = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [63:0]                     in_tdata,   // lon_in[31:0], lat_in[63:32]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [63:0]                     out_tdata,  // lon_out[31:0], lat_out[63:32]
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [scr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]                     cfg_data
);

  localparam int T_A = CORDIC_STAGES + 2;
  localparam int T_B = T_A + scr_pkg::MUL_LAT;
  localparam int T_C = T_B + scr_pkg::MUL_LAT;
  localparam int T_S = T_C + 2;
  localparam int T_D = T_S + scr_pkg::MUL_LAT;
  localparam int T_E = T_D + 1 + scr_pkg::SQRT_LAT;
  localparam int T_F = T_E + CORDIC_STAGES + 1;
  localparam int PIPE_LAT = T_F + 1;

  localparam logic [ANGLE_BITS+32:0] RND =
    (ANGLE_BITS > 32) ? ({{(ANGLE_BITS+32){1'b0}}, 1'b1} << (ANGLE_BITS - 1)) : '0;

  // 32-bit turn units to the internal phase width, truncating.
  function automatic logic [ANGLE_BITS-1:0] to_ang(input logic [31:0] v);
    logic [ANGLE_BITS+31:0] w;
    w = {v, {ANGLE_BITS{1'b0}}};
    return w[ANGLE_BITS+31:32];
  endfunction

  // Internal phase back to 32-bit turn units, rounding to nearest.
  function automatic logic [31:0] from_ang(input logic [ANGLE_BITS-1:0] p);
    logic [ANGLE_BITS+32:0] w;
    w = {1'b0, p, 32'd0} + RND;
    return w[ANGLE_BITS+31:ANGLE_BITS];
  endfunction

  // Configuration registers.
  logic [31:0] tilt_r, node_r, offset_r, tilt_nxt, node_nxt, offset_nxt;
  logic        ident_r, ident_nxt;

  always_comb begin
    tilt_nxt   = tilt_r;
    node_nxt   = node_r;
    offset_nxt = offset_r;
    ident_nxt  = ident_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        scr_pkg::REG_TILT:     tilt_nxt   = cfg_data;
        scr_pkg::REG_NODE:     node_nxt   = cfg_data;
        scr_pkg::REG_OFFSET:   offset_nxt = cfg_data;
        scr_pkg::REG_IDENTITY: ident_nxt  = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tilt_r   <= '0;
      node_r   <= '0;
      offset_r <= '0;
      ident_r  <= 1'b1;
    end else begin
      tilt_r   <= tilt_nxt;
      node_r   <= node_nxt;
      offset_r <= offset_nxt;
      ident_r  <= ident_nxt;
    end
  end

  assign cfg_ready = 1'b1;

  // Pipeline control: one enable for every stage.
  logic                en;
  logic                in_fire;
  logic [PIPE_LAT-1:0] vld_r, vld_nxt;

  assign en        = !vld_r[PIPE_LAT-1] || out_tready;
  assign in_tready = en;
  assign in_fire   = in_tvalid && en;
  assign vld_nxt   = {vld_r[PIPE_LAT-2:0], in_fire};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  // Sines and cosines of the inputs and of the tilt and node angles.
  scr_pkg::q_t cy, sy, cxi, sxi, cp, sp, cn, sn;

  scr_sincos #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_sc_lat (
    .clk(clk), .en(en), .ang(to_ang(in_tdata[63:32])), .cos_o(cy), .sin_o(sy));
  scr_sincos #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_sc_lon (
    .clk(clk), .en(en), .ang(to_ang(in_tdata[31:0])), .cos_o(cxi), .sin_o(sxi));
  scr_sincos #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_sc_tilt (
    .clk(clk), .en(en), .ang(to_ang(tilt_r)), .cos_o(cp), .sin_o(sp));
  scr_sincos #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_sc_node (
    .clk(clk), .en(en), .ang(to_ang(node_r)), .cos_o(cn), .sin_o(sn));

  // First round of products.
  scr_pkg::q_t cs, cc, spcn, spsn, cpcn, cpsn, sycp, sysp;

  scr_qmul u_cs   (.clk(clk), .en(en), .a(cy), .b(sxi), .p(cs));
  scr_qmul u_cc   (.clk(clk), .en(en), .a(cy), .b(cxi), .p(cc));
  scr_qmul u_spcn (.clk(clk), .en(en), .a(sp), .b(cn),  .p(spcn));
  scr_qmul u_spsn (.clk(clk), .en(en), .a(sp), .b(sn),  .p(spsn));
  scr_qmul u_cpcn (.clk(clk), .en(en), .a(cp), .b(cn),  .p(cpcn));
  scr_qmul u_cpsn (.clk(clk), .en(en), .a(cp), .b(sn),  .p(cpsn));
  scr_qmul u_sycp (.clk(clk), .en(en), .a(sy), .b(cp),  .p(sycp));
  scr_qmul u_sysp (.clk(clk), .en(en), .a(sy), .b(sp),  .p(sysp));

  scr_pkg::q_t cn_d, sn_d, sycp_d, sysp_d;

  scr_delay #(.WIDTH(128), .DEPTH(scr_pkg::MUL_LAT)) u_dly_node (
    .clk(clk), .en(en), .d({cn, sn}), .q({cn_d, sn_d}));
  scr_delay #(.WIDTH(128), .DEPTH(scr_pkg::MUL_LAT)) u_dly_sy (
    .clk(clk), .en(en), .d({sycp, sysp}), .q({sycp_d, sysp_d}));

  // Second round of products.
  scr_pkg::q_t m1, m2, m3, m4, m5, m6;

  scr_qmul u_m1 (.clk(clk), .en(en), .a(cs), .b(spcn), .p(m1));
  scr_qmul u_m2 (.clk(clk), .en(en), .a(cc), .b(spsn), .p(m2));
  scr_qmul u_m3 (.clk(clk), .en(en), .a(cs), .b(cpcn), .p(m3));
  scr_qmul u_m4 (.clk(clk), .en(en), .a(cc), .b(cpsn), .p(m4));
  scr_qmul u_m5 (.clk(clk), .en(en), .a(cc), .b(cn_d), .p(m5));
  scr_qmul u_m6 (.clk(clk), .en(en), .a(cs), .b(sn_d), .p(m6));

  // Sums, then saturation of the latitude sine to one.
  scr_pkg::q_t siny_sum_r, sinx_sum_r, cosx_sum_r;
  scr_pkg::q_t siny_sat_r, sinx_sat_r, cosx_sat_r, siny_sat_nxt;

  always_comb begin
    if (siny_sum_r > scr_pkg::Q_ONE) begin
      siny_sat_nxt = scr_pkg::Q_ONE;
    end else if (siny_sum_r < -scr_pkg::Q_ONE) begin
      siny_sat_nxt = -scr_pkg::Q_ONE;
    end else begin
      siny_sat_nxt = siny_sum_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      siny_sum_r <= m1 - m2 + sycp_d;
      sinx_sum_r <= m3 - m4 - sysp_d;
      cosx_sum_r <= m5 + m6;
      siny_sat_r <= siny_sat_nxt;
      sinx_sat_r <= sinx_sum_r;
      cosx_sat_r <= cosx_sum_r;
    end
  end

  // Cosine of the output latitude: sqrt(1 - sin_y^2).
  scr_pkg::q_t                     sq, d_val;
  logic [scr_pkg::SQRT_IN_W-1:0]   n_r, n_nxt;
  logic [scr_pkg::QF:0]            cosy;

  scr_qmul u_sq (.clk(clk), .en(en), .a(siny_sat_r), .b(siny_sat_r), .p(sq));

  // The truncated square of the root must not exceed d, which is the same
  // as root^2 <= d * 2^QF + 2^QF - 1.
  assign d_val = scr_pkg::Q_ONE - sq;
  assign n_nxt = {d_val[scr_pkg::QF:0], {scr_pkg::QF{1'b1}}};

  always_ff @(posedge clk) begin
    if (en) begin
      n_r <= n_nxt;
    end
  end

  scr_isqrt u_sqrt (.clk(clk), .en(en), .n(n_r), .root(cosy));

  scr_pkg::q_t siny_e, sinx_e, cosx_e;

  scr_delay #(.WIDTH(192), .DEPTH(T_E - T_S)) u_dly_sxy (
    .clk(clk), .en(en), .d({siny_sat_r, sinx_sat_r, cosx_sat_r}),
    .q({siny_e, sinx_e, cosx_e}));

  // Output angles.
  logic [ANGLE_BITS-1:0] zlat, zlon;

  scr_atan2 #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_at_lat (
    .clk(clk), .en(en), .y(siny_e), .x(scr_pkg::q_t'({3'b000, cosy})), .ang(zlat));
  scr_atan2 #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_at_lon (
    .clk(clk), .en(en), .y(sinx_e), .x(cosx_e), .ang(zlon));

  logic [63:0] pass_d;

  scr_delay #(.WIDTH(64), .DEPTH(T_F)) u_dly_pass (
    .clk(clk), .en(en), .d(in_tdata), .q(pass_d));

  // Final stage: offset, conversion to 32-bit units and latitude clamp, or identity pass-through.
  logic [31:0]        lon_out_r, lon_out_nxt, lat_out_r, lat_out_nxt;
  logic signed [31:0] lat_rot;

  always_comb begin
    lat_rot = $signed(from_ang(zlat));
    if (ident_r) begin
      lon_out_nxt = pass_d[31:0];
      lat_out_nxt = pass_d[63:32];
    end else begin
      lon_out_nxt = from_ang(zlon + to_ang(offset_r));
      if (lat_rot > scr_pkg::LAT_LIMIT) begin
        lat_out_nxt = scr_pkg::LAT_LIMIT;
      end else if (lat_rot < -scr_pkg::LAT_LIMIT) begin
        lat_out_nxt = -scr_pkg::LAT_LIMIT;
      end else begin
        lat_out_nxt = lat_rot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lon_out_r <= lon_out_nxt;
      lat_out_r <= lat_out_nxt;
    end
  end

  assign out_tvalid = vld_r[PIPE_LAT-1];
  assign out_tdata  = {lat_out_r, lon_out_r};

  // An accepted beat must occupy the first pipeline slot.
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> vld_r[0])
    else $error("accepted beat did not enter the pipeline");

  // While the output is stalled no slot may move or vanish.
  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline moved during a stall");

  // The square root of a value within one never exceeds one.
  a_cosy_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[T_E-1] |-> ({3'b000, cosy} <= 64'(scr_pkg::Q_ONE)))
    else $error("latitude cosine above one");

  // A rotated latitude stays within a quarter turn.
  a_lat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !ident_r |->
      ($signed(out_tdata[63:32]) <= scr_pkg::LAT_LIMIT &&
       $signed(out_tdata[63:32]) >= -scr_pkg::LAT_LIMIT))
    else $error("output latitude beyond a pole");

endmodule
